[src/pgb_pkg.sv]
// shared types and constants for the particle grid binning block
package pgb_pkg;

   localparam int POS_W        = 32;
   localparam int FRAC_W       = 16;
   localparam int GRID_RES_W   = 5;
   localparam int CELL_W_W     = 31;
   localparam int CELL_INDEX_W = 12;
   localparam int CELL_COUNT_W = 16;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 31;

   localparam logic [CSR_INDEX_W-1:0] CSR_GRID_RES       = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CELL_WIDTH     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_INV_CELL_WIDTH = 2'd2;

   localparam logic [GRID_RES_W-1:0] GRID_RES_RST       = 5'd16;
   localparam logic [CELL_W_W-1:0]   CELL_WIDTH_RST     = 31'd65536;
   localparam logic [CELL_W_W-1:0]   INV_CELL_WIDTH_RST = 31'd65536;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOCATE,
      ST_READ
   } state_type;

endpackage

[src/pgb_ram.sv]
// generic single-port-write, single-port-read ram with registered read
module pgb_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/pgb_locate.sv]
// position to linear cell index pipeline, six stages; the top level keeps one item in flight
module pgb_locate #(
   parameter int MAX_GRID_RES = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   input  logic signed [pgb_pkg::POS_W-1:0]       pos_x,
   input  logic signed [pgb_pkg::POS_W-1:0]       pos_y,
   input  logic signed [pgb_pkg::POS_W-1:0]       pos_z,
   input  logic [$clog2(((MAX_GRID_RES < 31) ? MAX_GRID_RES : 31) + 1)-1:0] res,
   input  logic [2*$clog2(((MAX_GRID_RES < 31) ? MAX_GRID_RES : 31) + 1)-1:0] res_sq,
   input  logic [$clog2(((MAX_GRID_RES < 31) ? MAX_GRID_RES : 31) + 1)
                 + pgb_pkg::CELL_W_W-1:0]         extent,
   input  logic [pgb_pkg::CELL_W_W-1:0]           inv,
   output logic                                   done,
   output logic                                   outside,
   output logic [$clog2(MAX_GRID_RES*MAX_GRID_RES*MAX_GRID_RES)-1:0] index
);

   import pgb_pkg::*;

   localparam int RES_CAP = (MAX_GRID_RES < 31) ? MAX_GRID_RES : 31;
   localparam int RES_W   = $clog2(RES_CAP + 1);
   localparam int SQ_W    = 2 * RES_W;
   localparam int CRD_W   = $clog2(RES_CAP);
   localparam int ADDR_W  = $clog2(MAX_GRID_RES * MAX_GRID_RES * MAX_GRID_RES);
   localparam int EXT_W   = RES_W + CELL_W_W;
   localparam int S_W     = EXT_W + 2;
   localparam int HI_W    = EXT_W - FRAC_W;
   localparam int PHI_W   = HI_W + CELL_W_W;
   localparam int PLO_W   = FRAC_W + CELL_W_W;
   localparam int SUM_W   = PHI_W + 1;
   localparam int C_W     = SUM_W - FRAC_W;
   localparam int PY_W    = CRD_W + RES_W;
   localparam int PZ_W    = CRD_W + SQ_W;
   localparam int IDX_W   = PZ_W + 2;

   logic [5:0]              v_ff;
   logic signed [POS_W-1:0] pos_ff [3];
   logic [EXT_W-1:0]        mag_ff [3];
   logic [EXT_W-1:0]        mag_in [3];
   logic                    out1_ff;
   logic                    out1_in;
   logic [PHI_W-1:0]        phi_ff [3];
   logic [PLO_W-1:0]        plo_ff [3];
   logic                    out2_ff;
   logic [CRD_W-1:0]        crd_ff [3];
   logic [CRD_W-1:0]        crd_in [3];
   logic                    out3_ff;
   logic [CRD_W-1:0]        cx_ff;
   logic [PY_W-1:0]         py_ff;
   logic [PZ_W-1:0]         pz_ff;
   logic                    out4_ff;
   logic [ADDR_W-1:0]       index_ff;
   logic                    out5_ff;

   // offset by half the extent and test the bounds
   always_comb begin
      logic signed [S_W-1:0] s;
      logic signed [S_W-1:0] half_s;
      logic signed [S_W-1:0] ext_s;
      half_s  = $signed({2'b00, (extent >> 1)});
      ext_s   = $signed({2'b00, extent});
      out1_in = 1'b0;
      for (int a = 0; a < 3; a++) begin
         s         = S_W'(pos_ff[a]) + half_s;
         mag_in[a] = s[EXT_W-1:0];
         if (s[S_W-1] || (s > ext_s)) begin
            out1_in = 1'b1;
         end
      end
   end

   // floor of the scaled offset, clamped on the upper face, zero when outside
   always_comb begin
      logic [SUM_W-1:0] sum;
      logic [C_W-1:0]   c;
      for (int a = 0; a < 3; a++) begin
         sum = SUM_W'(phi_ff[a]) + SUM_W'(plo_ff[a] >> FRAC_W);
         c   = sum[SUM_W-1:FRAC_W];
         if (out2_ff) begin
            crd_in[a] = '0;
         end else if (c >= C_W'(res)) begin
            crd_in[a] = CRD_W'(res - RES_W'(1));
         end else begin
            crd_in[a] = c[CRD_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= {v_ff[4:0], start};
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         pos_ff[0] <= pos_x;
         pos_ff[1] <= pos_y;
         pos_ff[2] <= pos_z;
      end
      mag_ff  <= mag_in;
      out1_ff <= out1_in;
      for (int a = 0; a < 3; a++) begin
         phi_ff[a] <= PHI_W'(mag_ff[a][EXT_W-1:FRAC_W]) * PHI_W'(inv);
         plo_ff[a] <= PLO_W'(mag_ff[a][FRAC_W-1:0]) * PLO_W'(inv);
      end
      out2_ff  <= out1_ff;
      crd_ff   <= crd_in;
      out3_ff  <= out2_ff;
      cx_ff    <= crd_ff[0];
      py_ff    <= PY_W'(crd_ff[1]) * PY_W'(res);
      pz_ff    <= PZ_W'(crd_ff[2]) * PZ_W'(res_sq);
      out4_ff  <= out3_ff;
      index_ff <= ADDR_W'(IDX_W'(cx_ff) + IDX_W'(py_ff) + IDX_W'(pz_ff));
      out5_ff  <= out4_ff;
   end

   assign done    = v_ff[5];
   assign outside = out5_ff;
   assign index   = index_ff;

endmodule

[src/particle_grid_binning.sv]
// top level of the particle grid binning block
// a result passes the six-stage locate pipeline, the registered occupancy ram read
//    and the result beat register, which is held while a previous result beat stalls
// one particle at a time: req_ready is high only in idle, after the previous write back
// reset: synchronous; registers return to defaults, then a clearing pass writes
//    zero to all MAX_GRID_RES**3 ram entries with req_ready low
module particle_grid_binning #(
   parameter int MAX_GRID_RES = 16,
   parameter int COUNT_BITS   = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [pgb_pkg::POS_W-1:0]      req_pos_x,
   input  logic signed [pgb_pkg::POS_W-1:0]      req_pos_y,
   input  logic signed [pgb_pkg::POS_W-1:0]      req_pos_z,
   input  logic                                  req_last_particle,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [pgb_pkg::CELL_INDEX_W-1:0]      rsp_cell_index,
   output logic                                  rsp_outside_grid,
   output logic [pgb_pkg::CELL_COUNT_W-1:0]      rsp_cell_count,
   output logic                                  rsp_last_result,
   input  logic                                  csr_wr_en,
   input  logic [pgb_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [pgb_pkg::CSR_DATA_W-1:0]        csr_wr_data
);

   import pgb_pkg::*;

   localparam int DEPTH   = MAX_GRID_RES * MAX_GRID_RES * MAX_GRID_RES;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int RES_CAP = (MAX_GRID_RES < 31) ? MAX_GRID_RES : 31;
   localparam int RES_W   = $clog2(RES_CAP + 1);
   localparam int SQ_W    = 2 * RES_W;
   localparam int EXT_W   = RES_W + CELL_W_W;

   state_type               state_ff;
   state_type               state_in;
   logic [ADDR_W-1:0]       clr_cnt_ff;
   logic [GRID_RES_W-1:0]   grid_res_ff;
   logic [CELL_W_W-1:0]     cell_width_ff;
   logic [CELL_W_W-1:0]     inv_cell_width_ff;
   logic [RES_W-1:0]        res_eff;
   logic [EXT_W-1:0]        extent_ff;
   logic [SQ_W-1:0]         res_sq_ff;
   logic                    last_ff;
   logic [ADDR_W-1:0]       addr_ff;
   logic                    outside_ff;
   logic                    rsp_valid_ff;
   logic [CELL_INDEX_W-1:0] rsp_cell_index_ff;
   logic                    rsp_outside_grid_ff;
   logic [CELL_COUNT_W-1:0] rsp_cell_count_ff;
   logic                    rsp_last_result_ff;

   logic                    accept;
   logic                    can_load;
   logic                    update;
   logic                    clr_last;
   logic                    loc_done;
   logic                    loc_outside;
   logic [ADDR_W-1:0]       loc_index;
   logic                    ram_wr_en;
   logic [ADDR_W-1:0]       ram_wr_addr;
   logic [COUNT_BITS-1:0]   ram_wr_data;
   logic                    ram_rd_en;
   logic [COUNT_BITS-1:0]   ram_rd_data;
   logic [COUNT_BITS-1:0]   count_next;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         grid_res_ff       <= GRID_RES_RST;
         cell_width_ff     <= CELL_WIDTH_RST;
         inv_cell_width_ff <= INV_CELL_WIDTH_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_GRID_RES:       grid_res_ff       <= csr_wr_data[GRID_RES_W-1:0];
            CSR_CELL_WIDTH:     cell_width_ff     <= csr_wr_data[CELL_W_W-1:0];
            CSR_INV_CELL_WIDTH: inv_cell_width_ff <= csr_wr_data[CELL_W_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (grid_res_ff == '0) begin
         res_eff = RES_W'(1);
      end else if (grid_res_ff > GRID_RES_W'(RES_CAP)) begin
         res_eff = RES_W'(RES_CAP);
      end else begin
         res_eff = RES_W'(grid_res_ff);
      end
   end

   // derived grid geometry
   always_ff @(posedge clock) begin
      extent_ff <= EXT_W'(res_eff) * EXT_W'(cell_width_ff);
      res_sq_ff <= SQ_W'(res_eff) * SQ_W'(res_eff);
   end

   assign accept     = req_valid && req_ready;
   assign can_load   = !rsp_valid_ff || rsp_ready;
   assign clr_last   = (clr_cnt_ff == ADDR_W'(DEPTH - 1));
   assign count_next = (ram_rd_data == '1) ? ram_rd_data : ram_rd_data + COUNT_BITS'(1);

   pgb_locate #(
      .MAX_GRID_RES (MAX_GRID_RES)
   ) u_locate (
      .clock   (clock),
      .reset   (reset),
      .start   (accept),
      .pos_x   (req_pos_x),
      .pos_y   (req_pos_y),
      .pos_z   (req_pos_z),
      .res     (res_eff),
      .res_sq  (res_sq_ff),
      .extent  (extent_ff),
      .inv     (inv_cell_width_ff),
      .done    (loc_done),
      .outside (loc_outside),
      .index   (loc_index)
   );

   pgb_ram #(
      .WIDTH (COUNT_BITS),
      .DEPTH (DEPTH)
   ) u_occupancy (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (loc_index),
      .rd_data (ram_rd_data)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_LOCATE;
            end
         end
         ST_LOCATE: begin
            if (loc_done) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            if (can_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // state outputs
   always_comb begin
      req_ready   = 1'b0;
      ram_wr_en   = 1'b0;
      ram_wr_addr = addr_ff;
      ram_wr_data = count_next;
      ram_rd_en   = 1'b0;
      update      = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_cnt_ff;
            ram_wr_data = '0;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
         end
         ST_LOCATE: begin
            ram_rd_en = loc_done;
         end
         ST_READ: begin
            ram_wr_en = can_load;
            update    = can_load;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         clr_cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) begin
            clr_cnt_ff <= clr_cnt_ff + ADDR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         last_ff <= req_last_particle;
      end
      if (loc_done) begin
         addr_ff    <= loc_index;
         outside_ff <= loc_outside;
      end
   end

   // result beat register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (update) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (update) begin
         rsp_cell_index_ff   <= CELL_INDEX_W'(addr_ff);
         rsp_outside_grid_ff <= outside_ff;
         rsp_cell_count_ff   <= CELL_COUNT_W'(count_next);
         rsp_last_result_ff  <= last_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_cell_index   = rsp_cell_index_ff;
   assign rsp_outside_grid = rsp_outside_grid_ff;
   assign rsp_cell_count   = rsp_cell_count_ff;
   assign rsp_last_result  = rsp_last_result_ff;

`ifndef ASSERT_OFF
   a_done_in_locate: assert property (@(posedge clock) disable iff (reset)
      loc_done |-> (state_ff == ST_LOCATE))
      else $error("locate finished outside the locate state");

   a_outside_cell_zero: assert property (@(posedge clock) disable iff (reset)
      (loc_done && loc_outside) |-> (loc_index == '0))
      else $error("outside particle not mapped to cell zero");

   a_no_read_write_clash: assert property (@(posedge clock) disable iff (reset)
      !(ram_wr_en && ram_rd_en))
      else $error("occupancy read and write in the same cycle");

   a_count_no_wrap: assert property (@(posedge clock) disable iff (reset)
      update |-> (count_next != '0))
      else $error("occupancy count wrapped");

   a_rsp_from_update: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_READ))
      else $error("result beat raised without an update");
`endif

endmodule

[tb/particle_grid_binning_checker.sv]
`timescale 1ns / 100ps
// checker for the particle grid binning block: bins each request beat and compares result beats
module particle_grid_binning_checker #(
   parameter int MAX_GRID_RES = 16,
   parameter int COUNT_BITS   = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   input  logic                                  req_ready,
   input  logic signed [pgb_pkg::POS_W-1:0]      req_pos_x,
   input  logic signed [pgb_pkg::POS_W-1:0]      req_pos_y,
   input  logic signed [pgb_pkg::POS_W-1:0]      req_pos_z,
   input  logic                                  req_last_particle,
   input  logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   input  logic [pgb_pkg::CELL_INDEX_W-1:0]      rsp_cell_index,
   input  logic                                  rsp_outside_grid,
   input  logic [pgb_pkg::CELL_COUNT_W-1:0]      rsp_cell_count,
   input  logic                                  rsp_last_result,
   input  logic                                  csr_wr_en,
   input  logic [pgb_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [pgb_pkg::CSR_DATA_W-1:0]        csr_wr_data,
   output int                                    fail_count,
   output int                                    pending
);
   import pgb_pkg::*;

   localparam int CELLS = MAX_GRID_RES ** 3;

   typedef struct packed {
      logic [CELL_INDEX_W-1:0] cell_index;
      logic                    outside_grid;
      logic [CELL_COUNT_W-1:0] cell_count;
      logic                    last_result;
   } bin_beat_type;

   logic [GRID_RES_W-1:0] cfg_res;
   logic [CELL_W_W-1:0]   cfg_cell_w;
   logic [CELL_W_W-1:0]   cfg_inv_w;
   logic [COUNT_BITS-1:0] cell_hits [CELLS];
   bin_beat_type          expected_bins [$];
   int                    errors = 0;
   int                    waiting = 0;

   assign fail_count = errors;
   assign pending    = waiting;

   function automatic bin_beat_type place_particle(input logic signed [POS_W-1:0] px, py, pz,
                                                   input logic last_flag);
      bin_beat_type            beat;
      logic signed [POS_W-1:0] pos [3];
      longint                  res, extent, half, s, idx;
      longint                  coord [3];
      logic [79:0]             prod;
      bit                      outside;
      res = cfg_res;
      if (res < 1) res = 1;
      if (res > MAX_GRID_RES) res = MAX_GRID_RES;
      extent  = res * longint'(cfg_cell_w);
      half    = extent >>> 1;
      pos     = '{px, py, pz};
      outside = 1'b0;
      for (int a = 0; a < 3; a++) begin
         coord[a] = 0;
         s = longint'(pos[a]) + half;
         if (s < 0 || s > extent) begin
            outside = 1'b1;
         end else begin
            // floor(s * inv / 2^32), then clamp a hit on the upper face
            prod     = s * cfg_inv_w;
            coord[a] = (prod[79:32] > res - 1) ? res - 1 : longint'(prod[79:32]);
         end
      end
      idx = outside ? 0 : coord[0] + coord[1] * res + coord[2] * res * res;
      if (idx >= CELLS) idx = 0;
      if (cell_hits[idx] != '1) cell_hits[idx] = cell_hits[idx] + 1'b1;
      beat.cell_index   = idx[CELL_INDEX_W-1:0];
      beat.outside_grid = outside;
      beat.cell_count   = CELL_COUNT_W'(cell_hits[idx]);
      beat.last_result  = last_flag;
      return beat;
   endfunction

   function automatic int field_mismatch(input string name, input longint unsigned want, got);
      if (want == got) return 0;
      $error("%s: expected %0d, actual %0d", name, want, got);
      return 1;
   endfunction

   always @(posedge clock) begin
      bin_beat_type want;
      if (reset) begin
         cfg_res    = GRID_RES_RST;
         cfg_cell_w = CELL_WIDTH_RST;
         cfg_inv_w  = INV_CELL_WIDTH_RST;
         foreach (cell_hits[i]) cell_hits[i] = '0;
         expected_bins.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_GRID_RES:       cfg_res    = csr_wr_data[GRID_RES_W-1:0];
               CSR_CELL_WIDTH:     cfg_cell_w = csr_wr_data[CELL_W_W-1:0];
               CSR_INV_CELL_WIDTH: cfg_inv_w  = csr_wr_data[CELL_W_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            expected_bins.push_back(place_particle(req_pos_x, req_pos_y, req_pos_z,
                                                   req_last_particle));
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_bins.size() == 0) begin
               $error("result beat with no particle outstanding");
               errors++;
            end else begin
               want = expected_bins.pop_front();
               errors += field_mismatch("cell_index", want.cell_index, rsp_cell_index);
               errors += field_mismatch("outside_grid", want.outside_grid, rsp_outside_grid);
               errors += field_mismatch("cell_count", want.cell_count, rsp_cell_count);
               errors += field_mismatch("last_result", want.last_result, rsp_last_result);
            end
         end
      end
      waiting <= expected_bins.size();
   end

endmodule

[tb/particle_grid_binning_tb.sv]
`timescale 1ns / 100ps
// testbench top for the particle grid binning block: clock, reset, stimulus and verdict
module particle_grid_binning_tb;
   import pgb_pkg::*;

   localparam int          MAX_GRID_RES    = 16;
   localparam int          COUNT_BITS      = 16;
   localparam int unsigned CYCLE_LIMIT     = 2_000_000;
   localparam int          HOLD_OFF_CYCLES = 200;
   localparam int          TAIL_PARTICLES  = 30;

   localparam logic signed [POS_W-1:0] P_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [POS_W-1:0] P_MIN = 32'sh8000_0000;
   localparam logic signed [POS_W-1:0] Q_ONE = 32'sd65536;
   localparam logic [CELL_W_W-1:0]     CELL_W_MAX = '1;
   localparam logic [CSR_INDEX_W-1:0]  CSR_UNUSED = 2'd3;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic signed [POS_W-1:0]  req_pos_x = '0;
   logic signed [POS_W-1:0]  req_pos_y = '0;
   logic signed [POS_W-1:0]  req_pos_z = '0;
   logic                     req_last_particle = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [CELL_INDEX_W-1:0]  rsp_cell_index;
   logic                     rsp_outside_grid;
   logic [CELL_COUNT_W-1:0]  rsp_cell_count;
   logic                     rsp_last_result;
   logic                     csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0]   csr_index = '0;
   logic [CSR_DATA_W-1:0]    csr_wr_data = '0;

   int                       fail_count;
   int                       pending;
   int unsigned              cycle_count = 0;
   bit                       req_gaps_on = 1'b1;
   bit                       rsp_stalls_on = 1'b1;
   int                       hold_offs_asked = 0;
   int                       hold_offs_done = 0;
   longint                   grid_extent = 16 * 65536;
   logic signed [POS_W-1:0]  prev_x = '0, prev_y = '0, prev_z = '0;

   particle_grid_binning #(
      .MAX_GRID_RES(MAX_GRID_RES),
      .COUNT_BITS  (COUNT_BITS)
   ) DUT (.*);

   particle_grid_binning_checker #(
      .MAX_GRID_RES(MAX_GRID_RES),
      .COUNT_BITS  (COUNT_BITS)
   ) bin_check (.*);

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin : rsp_side
      int n;
      @(posedge clock);
      rsp_ready <= 1'b1;
      forever begin
         @(posedge clock);
         if (hold_offs_done < hold_offs_asked) begin
            rsp_ready <= 1'b0;
            for (n = 0; n < HOLD_OFF_CYCLES; n++) @(posedge clock);
            hold_offs_done++;
            rsp_ready <= 1'b1;
         end else if (rsp_stalls_on && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
            rsp_ready <= 1'b1;
         end
      end
   end

   // mostly inside the current grid, with hits near both faces and some anywhere
   function automatic logic signed [POS_W-1:0] pick_axis();
      longint unsigned spread;
      longint          v;
      spread = {$urandom(), $urandom()};
      case ($urandom_range(0, 9))
         0: v = longint'($signed($urandom()));
         1: v = -(grid_extent >>> 1) + longint'($urandom_range(0, 2)) - 1;
         2: v = grid_extent - (grid_extent >>> 1) + longint'($urandom_range(0, 2)) - 1;
         default: v = -(grid_extent >>> 1) + longint'(spread % (grid_extent + 1));
      endcase
      if (v > longint'(P_MAX)) v = longint'(P_MAX);
      if (v < longint'(P_MIN)) v = longint'(P_MIN);
      return v[POS_W-1:0];
   endfunction

   task automatic offer_particle(input logic signed [POS_W-1:0] x, y, z,
                                 input logic last_flag);
      if (req_gaps_on && $urandom_range(0, 2) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_pos_x         <= x;
      req_pos_y         <= y;
      req_pos_z         <= z;
      req_last_particle <= last_flag;
      do @(posedge clock); while (!req_ready);
      prev_x = x;
      prev_y = y;
      prev_z = z;
   endtask

   task automatic random_particles(input int n);
      logic signed [POS_W-1:0] x, y, z;
      for (int i = 0; i < n; i++) begin
         if (i > 0 && $urandom_range(0, 5) == 0) begin
            x = prev_x;
            y = prev_y;
            z = prev_z;
         end else begin
            x = pick_axis();
            y = pick_axis();
            z = pick_axis();
         end
         offer_particle(x, y, z, $urandom_range(0, 7) == 0);
      end
   endtask

   task automatic wait_for_bins();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   task automatic reg_write(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(posedge clock);
   endtask

   task automatic set_grid(input logic [GRID_RES_W-1:0] res,
                           input logic [CELL_W_W-1:0] cw, icw);
      int used;
      used = (res == 0) ? 1 : ((res > MAX_GRID_RES) ? MAX_GRID_RES : int'(res));
      grid_extent = longint'(used) * longint'(cw);
      reg_write(CSR_GRID_RES, CSR_DATA_W'(res));
      reg_write(CSR_CELL_WIDTH, cw);
      reg_write(CSR_UNUSED, CSR_DATA_W'($urandom()));
      reg_write(CSR_INV_CELL_WIDTH, icw);
      csr_wr_en <= 1'b0;
   endtask

   initial begin : stimulus
      logic signed [POS_W-1:0] half_q;
      logic [GRID_RES_W-1:0]   res_sel;
      logic [CELL_W_W-1:0]     cw, icw;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset grid: 16 cells of 1.0 per axis, from -8.0 to +8.0
      half_q = 8 * Q_ONE;
      offer_particle(0, 0, 0, 1'b0);
      offer_particle(0, 0, 0, 1'b0);
      offer_particle(0, 0, 0, 1'b1);
      offer_particle(half_q, half_q, half_q, 1'b0);
      offer_particle(-half_q, -half_q, -half_q, 1'b0);
      offer_particle(half_q + 1, 0, 0, 1'b0);
      offer_particle(-half_q - 1, 0, 0, 1'b1);
      offer_particle(0, half_q + 1, 0, 1'b0);
      offer_particle(0, 0, -half_q - 1, 1'b0);
      offer_particle(P_MAX, P_MIN, 0, 1'b0);
      offer_particle(P_MIN, P_MIN, P_MIN, 1'b1);
      offer_particle(P_MAX, P_MAX, P_MAX, 1'b0);
      offer_particle(-1, -1, -1, 1'b0);
      offer_particle(half_q - 1, -half_q + 1, Q_ONE / 2, 1'b0);
      offer_particle(Q_ONE, 2 * Q_ONE, 3 * Q_ONE, 1'b0);
      offer_particle(-Q_ONE, -2 * Q_ONE, -3 * Q_ONE, 1'b0);
      offer_particle(Q_ONE, 2 * Q_ONE, 3 * Q_ONE, 1'b1);
      wait_for_bins();

      // zero size, zero width and zero reciprocal
      set_grid('0, '0, '0);
      offer_particle(0, 0, 0, 1'b0);
      offer_particle(1, 0, 0, 1'b0);
      offer_particle(0, -1, 0, 1'b1);
      offer_particle(0, 0, P_MAX, 1'b0);
      random_particles(8);
      wait_for_bins();

      set_grid('1, CELL_W_MAX, CELL_W_MAX);
      random_particles(30);
      wait_for_bins();

      set_grid(5'd1, 31'd1, CELL_W_MAX);
      random_particles(20);
      wait_for_bins();

      for (int ph = 0; ph < 8; ph++) begin
         cw  = CELL_W_W'($urandom_range(1 << 8, 1 << 22));
         icw = CELL_W_W'((64'd1 << 32) / cw + $urandom_range(0, 2) - 1);
         res_sel = ($urandom_range(0, 4) == 0) ? GRID_RES_W'($urandom_range(17, 31))
                                               : GRID_RES_W'($urandom_range(1, 16));
         set_grid(res_sel, cw, icw);
         req_gaps_on   = ($urandom_range(0, 3) != 0);
         rsp_stalls_on = ($urandom_range(0, 3) != 0);
         if (ph == 2) begin
            hold_offs_asked++;
            req_gaps_on = 1'b0;
         end
         random_particles(55);
         wait_for_bins();
      end

      // one cell hit back to back, no idling from here on
      req_gaps_on   = 1'b0;
      rsp_stalls_on = 1'b0;
      set_grid(5'd2, CELL_WIDTH_RST, INV_CELL_WIDTH_RST);
      repeat (TAIL_PARTICLES) offer_particle(Q_ONE / 2, Q_ONE / 2, Q_ONE / 2, 1'b0);
      offer_particle(Q_ONE / 2, Q_ONE / 2, Q_ONE / 2, 1'b1);
      wait_for_bins();
      repeat (16) @(posedge clock);

      if (fail_count == 0 && pending == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
